// File: src/chacha20_keystream_xor_defines.svh
// Assertion macros shared by the ChaCha20 keystream XOR RTL.
`ifndef CHACHA20_KEYSTREAM_XOR_DEFINES_SVH
`define CHACHA20_KEYSTREAM_XOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CC20_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CC20_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/cc20_pkg.sv
// Shared types, constants and state setup for the ChaCha20 keystream XOR block.
package cc20_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  localparam int unsigned RotA = 16;
  localparam int unsigned RotB = 12;
  localparam int unsigned RotC = 8;
  localparam int unsigned RotD = 7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_KEY01   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY23   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY45   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY67   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NONCE01 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NONCE2  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INITCTR = 3'd6;

  function automatic block_t init_block(
    input logic [63:0] key01,
    input logic [63:0] key23,
    input logic [63:0] key45,
    input logic [63:0] key67,
    input logic [63:0] nonce01,
    input word_t       nonce2,
    input word_t       ctr
  );
    block_t b;
    b[0]  = SIGMA0;
    b[1]  = SIGMA1;
    b[2]  = SIGMA2;
    b[3]  = SIGMA3;
    b[4]  = key01[31:0];
    b[5]  = key01[63:32];
    b[6]  = key23[31:0];
    b[7]  = key23[63:32];
    b[8]  = key45[31:0];
    b[9]  = key45[63:32];
    b[10] = key67[31:0];
    b[11] = key67[63:32];
    b[12] = ctr;
    b[13] = nonce01[31:0];
    b[14] = nonce01[63:32];
    b[15] = nonce2;
    return b;
  endfunction

endpackage

// File: src/cc20_mix_unit.sv
// Shared add, xor and rotate unit: one quarter-round step per use.
module cc20_mix_unit (
  input  cc20_pkg::word_t x_i,
  input  cc20_pkg::word_t y_i,
  input  cc20_pkg::word_t z_i,
  input  logic [1:0]      step_i,
  output cc20_pkg::word_t sum_o,
  output cc20_pkg::word_t mix_o
);

  cc20_pkg::word_t t;

  assign sum_o = x_i + y_i;
  assign t     = z_i ^ sum_o;

  always_comb begin
    case (step_i)
      2'd0: mix_o = {t[31-cc20_pkg::RotA:0], t[31:32-cc20_pkg::RotA]};
      2'd1: mix_o = {t[31-cc20_pkg::RotB:0], t[31:32-cc20_pkg::RotB]};
      2'd2: mix_o = {t[31-cc20_pkg::RotC:0], t[31:32-cc20_pkg::RotC]};
      default: mix_o = {t[31-cc20_pkg::RotD:0], t[31:32-cc20_pkg::RotD]};
    endcase
  end

endmodule

// File: src/chacha20_keystream_xor.sv
// ChaCha20 keystream XOR top level: config registers, round sequencer, output register.
// A word inside a block is accepted, then XORed into the output register once that is free.
// A word at a block boundary also runs the rounds, one quarter-round step at a time on the
// shared add/xor/rotate unit, then adds the initial state back word by word.
// Reset clears config, counter, position and handshakes; no clearing pass is needed.
`include "chacha20_keystream_xor_defines.svh"

module chacha20_keystream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cc20_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    data_word_i,
  input  logic [2:0]                     byte_count_i,
  input  logic                           first_word_i,
  input  logic                           last_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    xor_word_o,
  output logic                           out_last_o
);

  localparam int unsigned RcW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RcW-1:0] RcLast = RcW'(DOUBLE_ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e st_q, st_d;

  logic [63:0]     key01_q, key23_q, key45_q, key67_q, nonce01_q;
  cc20_pkg::word_t nonce2_q, initctr_q;

  cc20_pkg::word_t ctr_q, ctr_d;
  logic [3:0]      pos_q, pos_d;
  logic [1:0]      step_q, step_d;
  logic [1:0]      col_q, col_d;
  logic            diag_q, diag_d;
  logic [RcW-1:0]  rc_q, rc_d;
  logic [3:0]      add_idx_q, add_idx_d;
  logic            out_valid_q, out_valid_d;

  cc20_pkg::block_t w_q, w_d;
  cc20_pkg::word_t  data_q, data_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             last_q, last_d;
  cc20_pkg::word_t  xor_word_q, xor_word_d;
  logic             out_last_q, out_last_d;

  cc20_pkg::word_t  ctr_eff;
  logic [3:0]       pos_eff;
  cc20_pkg::block_t init_cur;
  cc20_pkg::word_t  x, y, z, sum, mix;
  logic             emit_go;
  logic [31:0]      mask;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign xor_word_o  = xor_word_q;
  assign out_last_o  = out_last_q;

  assign ctr_eff  = first_word_i ? initctr_q : ctr_q;
  assign pos_eff  = first_word_i ? 4'd0 : pos_q;
  assign init_cur = cc20_pkg::init_block(key01_q, key23_q, key45_q, key67_q,
                                         nonce01_q, nonce2_q, ctr_q);
  assign emit_go  = (st_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (st_q == ST_ADD) begin
      x = w_q[0];
      y = init_cur[add_idx_q];
      z = w_q[12];
    end else if (step_q[0]) begin
      x = w_q[8];
      y = w_q[12];
      z = w_q[4];
    end else begin
      x = w_q[0];
      y = w_q[4];
      z = w_q[12];
    end
  end

  cc20_mix_unit u_mix (
    .x_i    (x),
    .y_i    (y),
    .z_i    (z),
    .step_i (step_q),
    .sum_o  (sum),
    .mix_o  (mix)
  );

  always_comb begin
    case (cnt_q)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    cc20_pkg::block_t  w_n;
    logic [3:0][1:0]   shift;
    logic [1:0]        src;

    st_d        = st_q;
    ctr_d       = ctr_q;
    pos_d       = pos_q;
    step_d      = step_q;
    col_d       = col_q;
    diag_d      = diag_q;
    rc_d        = rc_q;
    add_idx_d   = add_idx_q;
    out_valid_d = out_valid_q;
    w_d         = w_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    xor_word_d  = xor_word_q;
    out_last_d  = out_last_q;
    w_n         = w_q;
    shift       = {2'd1, 2'd1, 2'd1, 2'd1};
    src         = 2'd0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          data_d = data_word_i;
          cnt_d  = byte_count_i;
          last_d = last_word_i;
          ctr_d  = ctr_eff;
          pos_d  = pos_eff;
          if (pos_eff == 4'd0) begin
            w_d    = cc20_pkg::init_block(key01_q, key23_q, key45_q, key67_q,
                                          nonce01_q, nonce2_q, ctr_eff);
            step_d = 2'd0;
            col_d  = 2'd0;
            diag_d = 1'b0;
            rc_d   = '0;
            st_d   = ST_ROUND;
          end else begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_ROUND: begin
        if (step_q[0]) begin
          w_n[8] = sum;
          w_n[4] = mix;
        end else begin
          w_n[0]  = sum;
          w_n[12] = mix;
        end
        if (col_q == 2'd3) begin
          // Skew rows into diagonals after the column round, back after the diagonal round.
          shift = diag_q ? {2'd2, 2'd3, 2'd0, 2'd1} : {2'd0, 2'd3, 2'd2, 2'd1};
        end
        w_d    = w_n;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 4; c++) begin
              src = 2'(c) + shift[k];
              w_d[4*k+c] = w_n[4*k+int'(src)];
            end
          end
          col_d = col_q + 2'd1;
          if (col_q == 2'd3) begin
            diag_d = ~diag_q;
            if (diag_q) begin
              if (rc_q == RcLast) begin
                add_idx_d = 4'd0;
                st_d      = ST_ADD;
              end else begin
                rc_d = rc_q + RcW'(1);
              end
            end
          end
        end
      end
      ST_ADD: begin
        w_d[14:0] = w_q[15:1];
        w_d[15]   = sum;
        add_idx_d = add_idx_q + 4'd1;
        if (add_idx_q == 4'd15) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          xor_word_d  = (data_q ^ w_q[pos_q]) & mask;
          out_last_d  = last_q;
          out_valid_d = 1'b1;
          pos_d       = pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            ctr_d = ctr_q + 32'd1;
          end
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ctr_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      col_q       <= '0;
      diag_q      <= 1'b0;
      rc_q        <= '0;
      add_idx_q   <= '0;
      out_valid_q <= 1'b0;
      key01_q     <= '0;
      key23_q     <= '0;
      key45_q     <= '0;
      key67_q     <= '0;
      nonce01_q   <= '0;
      nonce2_q    <= '0;
      initctr_q   <= '0;
    end else begin
      st_q        <= st_d;
      ctr_q       <= ctr_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      col_q       <= col_d;
      diag_q      <= diag_d;
      rc_q        <= rc_d;
      add_idx_q   <= add_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cc20_pkg::REG_KEY01:   key01_q   <= cfg_data_i;
          cc20_pkg::REG_KEY23:   key23_q   <= cfg_data_i;
          cc20_pkg::REG_KEY45:   key45_q   <= cfg_data_i;
          cc20_pkg::REG_KEY67:   key67_q   <= cfg_data_i;
          cc20_pkg::REG_NONCE01: nonce01_q <= cfg_data_i;
          cc20_pkg::REG_NONCE2:  nonce2_q  <= cfg_data_i[31:0];
          cc20_pkg::REG_INITCTR: initctr_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    data_q     <= data_d;
    cnt_q      <= cnt_d;
    last_q     <= last_d;
    xor_word_q <= xor_word_d;
    out_last_q <= out_last_d;
  end

  `CC20_ASSERT_NXT(a_block_start, clk_i, rst_ni,
                   in_valid_i && in_ready_o && (first_word_i || pos_q == 4'd0),
                   st_q == ST_ROUND, "block boundary word did not start the rounds")
  `CC20_ASSERT_IMP(a_round_bound, clk_i, rst_ni, st_q == ST_ROUND, rc_q <= RcLast,
                   "double round count out of range")
  `CC20_ASSERT_NXT(a_add_done, clk_i, rst_ni, st_q == ST_ADD && add_idx_q == 4'd15,
                   st_q == ST_EMIT, "add-back did not hand over to emit")
  `CC20_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, emit_go,
                   out_valid_q && st_q == ST_IDLE, "emitted word not presented")
  `CC20_ASSERT_NXT(a_ctr_step, clk_i, rst_ni, emit_go && pos_q == 4'd15,
                   ctr_q == $past(ctr_q) + 32'd1, "block counter did not advance")

endmodule

// File: verif/chacha20_stream_checker.sv
// Channel monitor, ChaCha20 keystream predictor and result comparison for the keystream XOR block.
module chacha20_stream_checker #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cc20_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [31:0]                    data_word_i,
  input  logic [2:0]                     byte_count_i,
  input  logic                           first_word_i,
  input  logic                           last_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [31:0]                    xor_word_i,
  input  logic                           out_last_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam cc20_pkg::word_t EXPAND_0 = 32'h61707865;
  localparam cc20_pkg::word_t EXPAND_1 = 32'h3320646e;
  localparam cc20_pkg::word_t EXPAND_2 = 32'h79622d32;
  localparam cc20_pkg::word_t EXPAND_3 = 32'h6b206574;

  typedef struct packed {
    cc20_pkg::word_t word;
    logic            last;
  } cipher_word_t;

  logic [63:0]      key01_q, key23_q, key45_q, key67_q, nonce01_q;
  cc20_pkg::word_t  nonce2_q, start_ctr_q, block_ctr_q;
  logic [3:0]       word_pos_q;
  cc20_pkg::block_t keystream_q;
  cipher_word_t     cipher_q[$];
  cipher_word_t     want;
  cc20_pkg::word_t  byte_mask;
  int unsigned      fails;

  function automatic cc20_pkg::word_t rotl(cc20_pkg::word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic cc20_pkg::block_t quarter_round(cc20_pkg::block_t w,
                                                     int unsigned a, b, c, d);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic cc20_pkg::block_t chacha_keystream(cc20_pkg::word_t ctr);
    cc20_pkg::block_t init;
    cc20_pkg::block_t w;
    int unsigned      r;
    int unsigned      i;
    init[0]  = EXPAND_0;
    init[1]  = EXPAND_1;
    init[2]  = EXPAND_2;
    init[3]  = EXPAND_3;
    init[4]  = key01_q[31:0];
    init[5]  = key01_q[63:32];
    init[6]  = key23_q[31:0];
    init[7]  = key23_q[63:32];
    init[8]  = key45_q[31:0];
    init[9]  = key45_q[63:32];
    init[10] = key67_q[31:0];
    init[11] = key67_q[63:32];
    init[12] = ctr;
    init[13] = nonce01_q[31:0];
    init[14] = nonce01_q[63:32];
    init[15] = nonce2_q;
    w = init;
    for (r = 0; r < DOUBLE_ROUNDS; r++) begin
      w = quarter_round(w, 0, 4, 8, 12);
      w = quarter_round(w, 1, 5, 9, 13);
      w = quarter_round(w, 2, 6, 10, 14);
      w = quarter_round(w, 3, 7, 11, 15);
      w = quarter_round(w, 0, 5, 10, 15);
      w = quarter_round(w, 1, 6, 11, 12);
      w = quarter_round(w, 2, 7, 8, 13);
      w = quarter_round(w, 3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q     = '0;
      key23_q     = '0;
      key45_q     = '0;
      key67_q     = '0;
      nonce01_q   = '0;
      nonce2_q    = '0;
      start_ctr_q = '0;
      block_ctr_q = '0;
      word_pos_q  = '0;
      keystream_q = '0;
      fails       = 0;
      cipher_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, actual %08h last %b",
                   $time, xor_word_i, out_last_i);
        end else begin
          want = cipher_q.pop_front();
          if (xor_word_i !== want.word) begin
            fails++;
            $display("%0t: xor_word expected %08h actual %08h", $time, want.word, xor_word_i);
          end
          if (out_last_i !== want.last) begin
            fails++;
            $display("%0t: out_last expected %b actual %b", $time, want.last, out_last_i);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cc20_pkg::REG_KEY01:   key01_q     = cfg_data_i;
          cc20_pkg::REG_KEY23:   key23_q     = cfg_data_i;
          cc20_pkg::REG_KEY45:   key45_q     = cfg_data_i;
          cc20_pkg::REG_KEY67:   key67_q     = cfg_data_i;
          cc20_pkg::REG_NONCE01: nonce01_q   = cfg_data_i;
          cc20_pkg::REG_NONCE2:  nonce2_q    = cfg_data_i[31:0];
          cc20_pkg::REG_INITCTR: start_ctr_q = cfg_data_i[31:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (first_word_i) begin
          block_ctr_q = start_ctr_q;
          word_pos_q  = '0;
        end
        if (word_pos_q == 4'd0) begin
          keystream_q = chacha_keystream(block_ctr_q);
        end
        byte_mask = (byte_count_i >= 3'd4) ? 32'hffff_ffff
                                           : (32'd1 << (8 * byte_count_i)) - 32'd1;
        want.word = (data_word_i ^ keystream_q[word_pos_q]) & byte_mask;
        want.last = last_word_i;
        cipher_q.push_back(want);
        word_pos_q = word_pos_q + 4'd1;
        if (word_pos_q == 4'd0) begin
          block_ctr_q = block_ctr_q + 32'd1;
        end
      end
    end
    fail_count_o = fails;
    pending_o    = cipher_q.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top: clock, reset, configuration phases, word traffic with random stalls, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 195;
  localparam logic [cc20_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef enum int unsigned {
    CFG_ALL_ONES,
    CFG_ALL_ZEROS,
    CFG_RANDOM
  } cfg_kind_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [cc20_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [cc20_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [31:0]                    data_word_i;
  logic [2:0]                     byte_count_i;
  logic                           first_word_i;
  logic                           last_word_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [31:0]                    xor_word_o;
  logic                           out_last_o;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned cycle_cnt;
  int unsigned words_sent;
  int unsigned stall_left;
  logic        burst_mode;

  chacha20_keystream_xor #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .first_word_i(first_word_i),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .xor_word_o  (xor_word_o),
    .out_last_o  (out_last_o)
  );

  chacha20_stream_checker #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) stream_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .first_word_i(first_word_i),
    .last_word_i (last_word_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .xor_word_i  (xor_word_o),
    .out_last_i  (out_last_o),
    .fail_count_o(fail_count),
    .pending_o   (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("chacha20_keystream_xor: mismatch");
    $finish;
  end

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!burst_mode && $urandom_range(0, 99) < 25) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  task automatic write_reg(input logic [cc20_pkg::CfgIdxW-1:0] idx,
                           input logic [cc20_pkg::CfgDataW-1:0] val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_word(input cc20_pkg::word_t data, input logic [2:0] cnt,
                           input logic first, input logic last);
    int unsigned gap;
    gap = (burst_mode || $urandom_range(0, 99) < 55) ? 0 : draw_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_word_i  = data;
    byte_count_i = cnt;
    first_word_i = first;
    last_word_i  = last;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    wait (words_pending == 0);
    @(negedge clk_i);
  endtask

  function automatic logic [cc20_pkg::CfgDataW-1:0] reg_value(cfg_kind_e kind);
    case (kind)
      CFG_ALL_ONES:  return '1;
      CFG_ALL_ZEROS: return '0;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  task automatic setup_phase(input cfg_kind_e kind, input logic spare);
    logic [cc20_pkg::CfgDataW-1:0] ctr;
    ctr = reg_value(kind);
    if (kind == CFG_RANDOM && $urandom_range(0, 1) == 1) begin
      ctr[31:0] = 32'hffff_ffff - $urandom_range(0, 3);
    end
    write_reg(cc20_pkg::REG_NONCE2,  reg_value(kind));
    write_reg(cc20_pkg::REG_KEY01,   reg_value(kind));
    write_reg(cc20_pkg::REG_KEY23,   reg_value(kind));
    write_reg(cc20_pkg::REG_INITCTR, ctr);
    write_reg(cc20_pkg::REG_KEY45,   reg_value(kind));
    write_reg(cc20_pkg::REG_KEY67,   reg_value(kind));
    write_reg(cc20_pkg::REG_NONCE01, reg_value(kind));
    if (spare) begin
      write_reg(REG_SPARE, {$urandom, $urandom});
    end
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_message();
    int unsigned     len;
    int unsigned     k;
    int unsigned     pick;
    logic            opens;
    cc20_pkg::word_t data;
    logic [2:0]      cnt;
    logic            first;
    logic            last;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
    burst_mode = ($urandom_range(0, 4) == 0);
    opens = ($urandom_range(0, 99) < 85);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 19);
      data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
      last = (k == len - 1);
      cnt  = last ? 3'($urandom_range(1, 4)) : 3'd4;
      if ($urandom_range(0, 99) < 6) begin
        cnt = 3'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 99) < 3) begin
        last = ~last;
      end
      first = (k == 0) ? opens : ($urandom_range(0, 99) < 2);
      send_word(data, cnt, first, last);
      words_sent++;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int unsigned k;
    int unsigned phase;
    cfg_kind_e   kind;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    first_word_i = 1'b0;
    last_word_i  = 1'b0;
    burst_mode   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (k = 0; k < 16; k++) begin
      send_word(32'h0, 3'd4, k == 0, k == 15);
    end
    send_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd1, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd5, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd6, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0, 1'b0);
    send_word(32'hffff_ffff, 3'd3, 1'b0, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1);
    send_word(32'ha5a5_5a5a, 3'd4, 1'b0, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        kind = (phase == 1) ? CFG_ALL_ONES :
               (phase == PHASES - 1) ? CFG_ALL_ZEROS : CFG_RANDOM;
        setup_phase(kind, phase == 4);
      end
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        send_message();
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("chacha20_keystream_xor: match");
    end else begin
      $display("chacha20_keystream_xor: mismatch");
    end
    $finish;
  end

endmodule
